// ===== rtl/core/fap_pkg.sv =====
// fap_pkg: shared types, codes and fixed-point constants of the ambisonic panner
// used by every module of the panner core; depends on nothing
`default_nettype none

package fap_pkg;

  // sample width of every input and output channel
  localparam int SAMPLE_BITS = 24;
  // width of the chunk length register and the ramp counter
  localparam int LEN_W = 13;

  // request kinds carried in tuser and in the command queue
  localparam logic [1:0] REQ_DIR   = 2'd0;
  localparam logic [1:0] REQ_POINT = 2'd1;
  localparam logic [1:0] REQ_DIFF  = 2'd2;

  // register indexes (byte address is four times the index)
  localparam logic [1:0] REG_SN3D  = 2'd0;
  localparam logic [1:0] REG_ACN   = 2'd1;
  localparam logic [1:0] REG_CHUNK = 2'd2;

  // gains in Q2.22
  localparam logic [23:0] W_FUMA_Q22    = 24'd2965821;
  localparam logic [23:0] W_SN3D_Q22    = 24'd4194304;
  localparam logic [23:0] DIFF_SN3D_Q22 = 24'd5931642;

  // register bank as seen by the front and back
  typedef struct packed {
    logic             sn3d_norm;
    logic             acn_order;
    logic [LEN_W-1:0] chunk_length;
  } cfg_t;

  // one queued command: direction targets (W,X,Y,Z low to high), a point
  // sample in the low lane, or four diffuse samples (W,X,Y,Z low to high)
  typedef struct packed {
    logic [1:0]  kind;
    logic [95:0] data;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/fap_front.sv =====
// fap_front: accepts input items, forwards samples and turns positions into
// unit-vector targets (shift, sum of squares, bit-serial root and divide); uses fap_pkg
`default_nettype none

module fap_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  [1:0]          in_kind,
  input  wire  [215:0]        in_data,
  input  fap_pkg::cfg_t       cfg,
  output logic                push_valid,
  input  wire                 push_ready,
  output fap_pkg::cmd_t       push_cmd
);

  localparam logic [2:0] F_IDLE   = 3'd0;
  localparam logic [2:0] F_SHIFT  = 3'd1;
  localparam logic [2:0] F_SQ     = 3'd2;
  localparam logic [2:0] F_SQRT   = 3'd3;
  localparam logic [2:0] F_DIVSET = 3'd4;
  localparam logic [2:0] F_DIV    = 3'd5;
  localparam logic [2:0] F_PUSH   = 3'd6;

  logic [2:0]  state;
  logic [31:0] mag [3];
  logic [2:0]  sgn;
  logic [31:0] mx;
  logic [1:0]  k;
  logic [63:0] sq;
  logic [63:0] acc;
  logic [63:0] n;
  logic [63:0] r;
  logic [63:0] bitv;
  logic [31:0] norm;
  logic [54:0] rem;
  logic [54:0] dsh;
  logic [22:0] q;
  logic [4:0]  cnt;
  logic [23:0] tw;
  logic [23:0] tgt [3];

  logic [31:0] mag_in [3];
  logic [31:0] mx_in;
  logic [31:0] mag_k;
  logic [63:0] rb;
  logic        ge;
  logic [22:0] q_next;
  logic        accept;

  assign in_ready = (state == F_IDLE) && push_ready;
  assign accept   = in_valid && in_ready;

  // magnitudes of the incoming position and their maximum
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_in[i] = in_data[32*i+31] ? 32'(-in_data[32*i +: 32]) : in_data[32*i +: 32];
    end
    mx_in = mag_in[0];
    if (mag_in[1] > mx_in) mx_in = mag_in[1];
    if (mag_in[2] > mx_in) mx_in = mag_in[2];
  end

  // component picked by the shared square and divide steps
  always_comb begin
    case (k)
      2'd0:    mag_k = mag[0];
      2'd1:    mag_k = mag[1];
      2'd2:    mag_k = mag[2];
      default: mag_k = mag[0];
    endcase
  end

  assign rb     = r + bitv;
  assign ge     = rem >= dsh;
  assign q_next = {q[21:0], ge};

  // queue write: samples pass straight through, targets after the sequence
  always_comb begin
    push_valid = (state == F_PUSH) ||
                 (accept && (in_kind == fap_pkg::REQ_POINT || in_kind == fap_pkg::REQ_DIFF));
    if (state == F_PUSH) begin
      push_cmd.kind = fap_pkg::REQ_DIR;
      push_cmd.data = {tgt[2], tgt[1], tgt[0], tw};
    end else if (in_kind == fap_pkg::REQ_POINT) begin
      push_cmd.kind = fap_pkg::REQ_POINT;
      push_cmd.data = {72'd0, in_data[119:96]};
    end else begin
      push_cmd.kind = fap_pkg::REQ_DIFF;
      push_cmd.data = in_data[215:120];
    end
  end

  // direction sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept && in_kind == fap_pkg::REQ_DIR) begin
            for (int i = 0; i < 3; i++) begin
              mag[i] <= mag_in[i];
              sgn[i] <= in_data[32*i+31];
              tgt[i] <= 24'd0;
            end
            mx <= mx_in;
            tw <= cfg.sn3d_norm ? fap_pkg::W_SN3D_Q22 : fap_pkg::W_FUMA_Q22;
            state <= (mx_in == 32'd0) ? F_PUSH : F_SHIFT;
          end
        end
        F_SHIFT: begin
          if (mx[31:30] == 2'b00) begin
            for (int i = 0; i < 3; i++) mag[i] <= {mag[i][30:0], 1'b0};
            mx <= {mx[30:0], 1'b0};
          end else begin
            k     <= 2'd0;
            acc   <= 64'd0;
            state <= F_SQ;
          end
        end
        F_SQ: begin
          // square one component, add the previous one
          if (k != 2'd3) sq <= 64'(mag_k) * 64'(mag_k);
          if (k != 2'd0) acc <= acc + sq;
          if (k == 2'd3) begin
            n     <= acc + sq;
            r     <= 64'd0;
            bitv  <= 64'd1 << 62;
            state <= F_SQRT;
          end
          k <= k + 2'd1;
        end
        F_SQRT: begin
          if (n >= rb) begin
            n <= n - rb;
            r <= (r >> 1) + bitv;
          end else begin
            r <= r >> 1;
          end
          bitv <= bitv >> 2;
          if (bitv[0]) begin
            norm  <= (n >= rb) ? 32'((r >> 1) + bitv) : 32'(r >> 1);
            k     <= 2'd0;
            state <= F_DIVSET;
          end
        end
        F_DIVSET: begin
          rem   <= ({23'd0, mag_k} << 22) + {23'd0, norm >> 1};
          dsh   <= {1'b0, norm, 22'd0};
          q     <= 23'd0;
          cnt   <= 5'd22;
          state <= F_DIV;
        end
        F_DIV: begin
          if (ge) rem <= rem - dsh;
          dsh <= dsh >> 1;
          q   <= q_next;
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            tgt[k] <= sgn[k] ? 24'(-{1'b0, q_next}) : {1'b0, q_next};
            if (k == 2'd2) begin
              state <= F_PUSH;
            end else begin
              k     <= k + 2'd1;
              state <= F_DIVSET;
            end
          end
        end
        F_PUSH: begin
          if (push_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fap_queue.sv =====
// fap_queue: two-entry command queue between the front and the back
// uses fap_pkg for the command type
`default_nettype none

module fap_queue (
  input  wire            clk,
  input  wire            rst,
  input  wire            push_valid,
  output logic           push_ready,
  input  fap_pkg::cmd_t  push_cmd,
  output logic           pop_valid,
  input  wire            pop_ready,
  output fap_pkg::cmd_t  pop_cmd
);

  fap_pkg::cmd_t mem [2];
  logic          wp;
  logic          rp;
  logic [1:0]    count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_cmd    = mem[rp];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wp] <= push_cmd;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      if (do_push && !do_pop) count <= count + 2'd1;
      else if (do_pop && !do_push) count <= count - 2'd1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fap_back.sv =====
// fap_back: weight ramp, step division, weighting multiplies, saturation and
// output register of the panner; uses fap_pkg
`default_nettype none

module fap_back #(
  parameter int MAX_CHUNK_LEN = 4096
) (
  input  wire            clk,
  input  wire            rst,
  input  fap_pkg::cfg_t  cfg,
  input  wire            pop_valid,
  output logic           pop_ready,
  input  fap_pkg::cmd_t  pop_cmd,
  output logic           out_valid,
  input  wire            out_ready,
  output logic [96:0]    out_word
);

  localparam int LW = fap_pkg::LEN_W;
  localparam int SB = fap_pkg::SAMPLE_BITS;
  localparam logic signed [47:0] SMAX = (48'sd1 <<< (SB - 1)) - 48'sd1;
  localparam logic signed [47:0] SMIN = -(48'sd1 <<< (SB - 1));

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_DSET = 3'd1;
  localparam logic [2:0] B_DIV  = 3'd2;
  localparam logic [2:0] B_UPD  = 3'd3;
  localparam logic [2:0] B_MUL  = 3'd4;
  localparam logic [2:0] B_RND  = 3'd5;
  localparam logic [2:0] B_OUT  = 3'd6;

  logic [2:0]         state;
  logic signed [23:0] tgt  [4];
  logic signed [39:0] cur  [4];
  logic signed [39:0] step [4];
  logic [LW-1:0]      ramp;
  logic [LW-1:0]      len;
  logic [1:0]         k;
  logic signed [23:0] smp;
  logic               neg;
  logic [41:0]        dq;
  logic [LW-1:0]      drem;
  logic [5:0]         cnt;
  logic signed [44:0] p_hi;
  logic signed [43:0] p_lo;
  logic [23:0]        v [4];
  logic               clip;

  logic [LW-1:0]      len_eff;
  logic signed [41:0] diff;
  logic [LW:0]        rs;
  logic               dge;
  logic [41:0]        dq_next;
  logic signed [47:0] rnd;
  logic [24:0]        sat_m;
  logic signed [49:0] dprod;
  logic [24:0]        sat_d [4];

  // clamp to the signed sample range, top bit flags a clamp
  function automatic logic [24:0] sat(input logic signed [47:0] x);
    logic [24:0] res;
    if (x > SMAX) res = {1'b1, SMAX[23:0]};
    else if (x < SMIN) res = {1'b1, SMIN[23:0]};
    else res = {1'b0, x[23:0]};
    return res;
  endfunction

  // effective ramp length
  always_comb begin
    if (cfg.chunk_length == '0) len_eff = LW'(1);
    else if ({4'd0, cfg.chunk_length} > 17'(MAX_CHUNK_LEN)) len_eff = LW'(MAX_CHUNK_LEN);
    else len_eff = cfg.chunk_length;
  end

  // step division datapath, one quotient bit a cycle
  assign diff    = {{2{tgt[k][23]}}, tgt[k], 16'd0} - {{2{cur[k][39]}}, cur[k]};
  assign rs      = {drem, dq[41]};
  assign dge     = rs >= {1'b0, len};
  assign dq_next = {dq[40:0], dge};

  // rounding of the weighted sample to Q1.23
  always_comb begin
    logic signed [47:0] b;
    b     = $signed({{4{p_lo[43]}}, p_lo}) + (48'sd1 <<< 37);
    rnd   = ($signed({{3{p_hi[44]}}, p_hi}) + (b >>> 19)) >>> 19;
    sat_m = sat(rnd);
  end

  // diffuse path: W gain for SN3D, the rest passes through
  always_comb begin
    logic signed [49:0] wr;
    dprod = 50'($signed(pop_cmd.data[23:0])) *
            50'($signed({1'b0, fap_pkg::DIFF_SN3D_Q22}));
    wr    = (dprod + (50'sd1 <<< 21)) >>> 22;
    if (cfg.sn3d_norm) sat_d[0] = sat(wr[47:0]);
    else sat_d[0] = {1'b0, pop_cmd.data[23:0]};
    for (int i = 1; i < 4; i++) sat_d[i] = {1'b0, pop_cmd.data[24*i +: 24]};
  end

  assign pop_ready = (state == B_IDLE);

  // command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      ramp  <= '0;
      for (int i = 0; i < 4; i++) begin
        tgt[i]  <= '0;
        cur[i]  <= '0;
        step[i] <= '0;
      end
    end else begin
      case (state)
        B_IDLE: begin
          if (pop_valid) begin
            case (pop_cmd.kind)
              fap_pkg::REQ_DIR: begin
                for (int i = 0; i < 4; i++) tgt[i] <= pop_cmd.data[24*i +: 24];
                len   <= len_eff;
                k     <= 2'd0;
                state <= B_DSET;
              end
              fap_pkg::REQ_POINT: begin
                smp   <= pop_cmd.data[23:0];
                state <= B_UPD;
              end
              fap_pkg::REQ_DIFF: begin
                for (int i = 0; i < 4; i++) v[i] <= sat_d[i][23:0];
                clip  <= sat_d[0][24];
                state <= B_OUT;
              end
              default: state <= B_IDLE;
            endcase
          end
        end
        B_DSET: begin
          neg   <= diff[41];
          dq    <= diff[41] ? 42'(-diff) : diff;
          drem  <= '0;
          cnt   <= 6'd41;
          state <= B_DIV;
        end
        B_DIV: begin
          drem <= dge ? LW'(rs - {1'b0, len}) : rs[LW-1:0];
          dq   <= dq_next;
          cnt  <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            step[k] <= neg ? 40'(-dq_next) : dq_next[39:0];
            if (k == 2'd3) begin
              ramp  <= len;
              state <= B_IDLE;
            end else begin
              k     <= k + 2'd1;
              state <= B_DSET;
            end
          end
        end
        B_UPD: begin
          // step the ramp, snap to the targets on its last sample
          if (ramp != '0) begin
            for (int i = 0; i < 4; i++) begin
              cur[i] <= (ramp == LW'(1)) ? {tgt[i], 16'd0} : cur[i] + step[i];
            end
            ramp <= ramp - LW'(1);
          end
          clip  <= 1'b0;
          k     <= 2'd0;
          state <= B_MUL;
        end
        B_MUL: begin
          p_hi  <= 45'($signed(cur[k][39:19])) * 45'(smp);
          p_lo  <= 44'($signed({1'b0, cur[k][18:0]})) * 44'(smp);
          state <= B_RND;
        end
        B_RND: begin
          v[k] <= sat_m[23:0];
          clip <= clip | sat_m[24];
          if (k == 2'd3) begin
            state <= B_OUT;
          end else begin
            k     <= k + 2'd1;
            state <= B_MUL;
          end
        end
        B_OUT: begin
          if (!out_valid || out_ready) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // output register, channel order chosen at load time
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == B_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_OUT && (!out_valid || out_ready)) begin
      if (cfg.acn_order) out_word <= {clip, v[1], v[3], v[2], v[0]};
      else out_word <= {clip, v[3], v[2], v[1], v[0]};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/first_order_ambisonic_panner_core.sv =====
// first_order_ambisonic_panner_core: top level with register bank, front,
// command queue and back; depends on fap_pkg, fap_front, fap_queue, fap_back
`default_nettype none

// Encodes one mono source into first-order ambisonics. A point sample passes
// through the back as the queue pop, one weight update, a multiply and a
// rounding step per channel, then the output register load; a diffuse
// sample passes as the queue pop and the output register load. A direction
// update runs in the front through normalizing shifts, the squares, the
// bit-serial root and three 23-bit divisions, and then in the back through
// the four 42-bit step divisions; samples behind it wait in the two-entry
// queue. The input accepts items while a result waits in the output
// register.

module first_order_ambisonic_panner_core #(
  parameter int MAX_CHUNK_LEN = 4096
) (
  input  wire           clk,
  input  wire           rst,
  // stream in
  input  wire           s_tvalid,
  output logic          s_tready,
  // pos_x, pos_y, pos_z, mono_sample, diff_w, diff_x, diff_y, diff_z
  input  wire  [215:0]  s_tdata,
  // req_type
  input  wire  [1:0]    s_tuser,
  // stream out
  output logic          m_tvalid,
  input  wire           m_tready,
  // out_ch0, out_ch1, out_ch2, out_ch3, clipped, zero fill
  output logic [103:0]  m_tdata,
  // register port
  input  wire           psel,
  input  wire           penable,
  input  wire           pwrite,
  input  wire  [3:0]    paddr,
  input  wire  [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  fap_pkg::cfg_t cfg;
  fap_pkg::cmd_t push_cmd;
  fap_pkg::cmd_t pop_cmd;
  logic          push_valid;
  logic          push_ready;
  logic          pop_valid;
  logic          pop_ready;
  logic [96:0]   out_word;

  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sn3d_norm    <= 1'b0;
      cfg.acn_order    <= 1'b1;
      cfg.chunk_length <= fap_pkg::LEN_W'(64);
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        fap_pkg::REG_SN3D:  cfg.sn3d_norm    <= pwdata[0];
        fap_pkg::REG_ACN:   cfg.acn_order    <= pwdata[0];
        fap_pkg::REG_CHUNK: cfg.chunk_length <= pwdata[fap_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[3:2])
      fap_pkg::REG_SN3D:  prdata = {31'd0, cfg.sn3d_norm};
      fap_pkg::REG_ACN:   prdata = {31'd0, cfg.acn_order};
      fap_pkg::REG_CHUNK: prdata = {{(32-fap_pkg::LEN_W){1'b0}}, cfg.chunk_length};
      default:            prdata = 32'd0;
    endcase
  end

  fap_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_kind    (s_tuser),
    .in_data    (s_tdata),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  fap_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  fap_back #(
    .MAX_CHUNK_LEN (MAX_CHUNK_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (out_word)
  );

  assign m_tdata = {7'd0, out_word};

endmodule

`default_nettype wire

// ===== rtl/core/fap_checker.sv =====
// fap_checker: port-level assertions for the panner core, bound to the top
// level; depends on fap_pkg and first_order_ambisonic_panner_core
`default_nettype none

module fap_checker (
  input wire          clk,
  input wire          rst,
  input wire          s_tvalid,
  input wire          s_tready,
  input wire [1:0]    s_tuser,
  input wire          m_tvalid,
  input wire          m_tready,
  input wire [103:0]  m_tdata,
  input wire          psel,
  input wire          penable,
  input wire          pwrite,
  input wire [3:0]    paddr,
  input wire [31:0]   pwdata,
  input wire [31:0]   prdata
);

  logic any_limit;

  // some channel sits at a saturation limit
  always_comb begin
    any_limit = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (m_tdata[24*i +: 24] == 24'h7fffff || m_tdata[24*i +: 24] == 24'h800000)
        any_limit = 1'b1;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // a direction transfer occupies the front
  a_dir_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == fap_pkg::REQ_DIR |=> !s_tready)
    else $error("input ready right after a direction transfer");

  // clipped only with a channel at a limit
  a_clip: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[96] |-> any_limit)
    else $error("clipped set without a saturated channel");

  // chunk length reads back what was written
  a_chunk_rb: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && paddr[3:2] == fap_pkg::REG_CHUNK
    |=> paddr[3:2] != fap_pkg::REG_CHUNK || prdata[12:0] == $past(pwdata[12:0]))
    else $error("chunk length read back mismatch");

endmodule

bind first_order_ambisonic_panner_core fap_checker u_fap_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite),
  .paddr    (paddr),
  .pwdata   (pwdata),
  .prdata   (prdata)
);

`default_nettype wire

// ===== tb/first_order_ambisonic_panner_core_chk.sv =====
// first_order_ambisonic_panner_core_chk: watches the register port and both streams,
// predicts every output transfer of the panner and compares it; depends on fap_pkg
`default_nettype none

module first_order_ambisonic_panner_core_chk (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  input  wire          s_tready,
  input  wire [215:0]  s_tdata,
  input  wire [1:0]    s_tuser,
  input  wire          m_tvalid,
  input  wire          m_tready,
  input  wire [103:0]  m_tdata,
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire          pready,
  input  wire [3:0]    paddr,
  input  wire [31:0]   pwdata,
  output int           fail_count,
  output int           pending
);

  localparam int MAX_LEN = 4096;
  localparam longint SAT_HI = (64'sd1 <<< (fap_pkg::SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO = -(64'sd1 <<< (fap_pkg::SAMPLE_BITS - 1));

  typedef struct packed {
    logic [3:0][23:0] ch;
    logic             clip;
  } pan_out_t;

  pan_out_t expected_outs[$];

  // shadow registers and panner state
  logic                      sn3d;
  logic                      acn;
  logic [fap_pkg::LEN_W-1:0] chunk;
  longint                    tgt_w[4];
  longint                    cur_w[4];
  longint                    step_w[4];
  int                        ramp_left;

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // round half up of the Q2.38 by Q1.23 product back to Q1.23
  function automatic longint weigh(longint w, longint smp);
    logic signed [127:0] pr;
    logic signed [127:0] a;
    logic signed [127:0] b;
    a = w;
    b = smp;
    pr = a * b + (128'sd1 <<< 37);
    pr = pr >>> 38;
    return longint'(pr);
  endfunction

  function automatic int ramp_len();
    if (chunk == 0) return 1;
    if (chunk > MAX_LEN) return MAX_LEN;
    return int'(chunk);
  endfunction

  task automatic new_direction(logic [95:0] d);
    longint p[3];
    longint m;
    longint unsigned sum;
    longint unsigned nrm;
    longint unsigned q;
    int sh;
    int len;
    m = 0;
    sum = 0;
    sh = 0;
    len = ramp_len();
    for (int k = 0; k < 3; k++) begin
      p[k] = longint'($signed(d[32*k +: 32]));
      if (mag(p[k]) > m) m = mag(p[k]);
    end
    tgt_w[0] = sn3d ? longint'(fap_pkg::W_SN3D_Q22) : longint'(fap_pkg::W_FUMA_Q22);
    if (m == 0) begin
      for (int k = 1; k < 4; k++) tgt_w[k] = 0;
    end else begin
      while ((m <<< sh) < (64'sd1 <<< 30)) sh++;
      for (int k = 0; k < 3; k++) begin
        p[k] = p[k] <<< sh;
        sum = sum + longint'(p[k] * p[k]);
      end
      nrm = isqrt(sum);
      for (int k = 0; k < 3; k++) begin
        q = ((longint'(mag(p[k])) << 22) + nrm / 2) / nrm;
        tgt_w[k+1] = (p[k] < 0) ? -longint'(q) : longint'(q);
      end
    end
    for (int k = 0; k < 4; k++)
      step_w[k] = ((tgt_w[k] <<< 16) - cur_w[k]) / longint'(len);
    ramp_left = len;
  endtask

  task automatic predict(logic [1:0] kind, logic [215:0] d);
    longint v[4];
    longint smp;
    pan_out_t o;
    o.clip = 1'b0;
    if (kind == fap_pkg::REQ_DIR) begin
      new_direction(d[95:0]);
      return;
    end
    if (kind == fap_pkg::REQ_POINT) begin
      smp = longint'($signed(d[119:96]));
      if (ramp_left > 0) begin
        for (int k = 0; k < 4; k++) cur_w[k] = cur_w[k] + step_w[k];
        ramp_left--;
        if (ramp_left == 0)
          for (int k = 0; k < 4; k++) cur_w[k] = tgt_w[k] <<< 16;
      end
      for (int k = 0; k < 4; k++) v[k] = weigh(cur_w[k], smp);
    end else if (kind == fap_pkg::REQ_DIFF) begin
      for (int k = 0; k < 4; k++) v[k] = longint'($signed(d[120 + 24*k +: 24]));
      if (sn3d)
        v[0] = (v[0] * longint'(fap_pkg::DIFF_SN3D_Q22) + (64'sd1 <<< 21)) >>> 22;
    end else begin
      return;
    end
    // clamp to the sample range
    for (int k = 0; k < 4; k++) begin
      if (v[k] > SAT_HI) begin v[k] = SAT_HI; o.clip = 1'b1; end
      if (v[k] < SAT_LO) begin v[k] = SAT_LO; o.clip = 1'b1; end
    end
    o.ch[0] = v[0][23:0];
    if (acn) begin
      o.ch[1] = v[2][23:0];
      o.ch[2] = v[3][23:0];
      o.ch[3] = v[1][23:0];
    end else begin
      o.ch[1] = v[1][23:0];
      o.ch[2] = v[2][23:0];
      o.ch[3] = v[3][23:0];
    end
    expected_outs = {expected_outs, o};
  endtask

  task automatic report(string what, logic [31:0] exp_v, logic [31:0] act_v);
    fail_count++;
    $display("%0t mismatch %s expected %h actual %h", $realtime, what, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    pan_out_t e;
    if (rst) begin
      sn3d = 1'b0;
      acn = 1'b1;
      chunk = 13'd64;
      for (int k = 0; k < 4; k++) begin
        tgt_w[k] = 0;
        cur_w[k] = 0;
        step_w[k] = 0;
      end
      ramp_left = 0;
      expected_outs.delete();
    end else begin
      // register write
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          fap_pkg::REG_SN3D:  sn3d = pwdata[0];
          fap_pkg::REG_ACN:   acn = pwdata[0];
          fap_pkg::REG_CHUNK: chunk = pwdata[fap_pkg::LEN_W-1:0];
          default:            ;
        endcase
      end
      // input transfer
      if (s_tvalid && s_tready) predict(s_tuser, s_tdata);
      // output transfer
      if (m_tvalid && m_tready) begin
        if (expected_outs.size() == 0) begin
          report("unexpected transfer", 32'd0, m_tdata[31:0]);
        end else begin
          e = expected_outs.pop_front();
          for (int k = 0; k < 4; k++)
            if (m_tdata[24*k +: 24] !== e.ch[k])
              report($sformatf("out_ch%0d", k), e.ch[k], m_tdata[24*k +: 24]);
          if (m_tdata[96] !== e.clip) report("clipped", e.clip, m_tdata[96]);
        end
      end
    end
    pending = expected_outs.size();
  end

endmodule

`default_nettype wire

// ===== tb/first_order_ambisonic_panner_core_tb.sv =====
// first_order_ambisonic_panner_core_tb: stimulus, handshake pacing and verdict for
// the panner core; depends on it, fap_pkg and first_order_ambisonic_panner_core_chk
`default_nettype none

module first_order_ambisonic_panner_core_tb;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE = 400;

  logic          clk;
  logic          rst;
  logic          s_tvalid;
  logic          s_tready;
  logic [215:0]  s_tdata;
  logic [1:0]    s_tuser;
  logic          m_tvalid;
  logic          m_tready;
  logic [103:0]  m_tdata;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [3:0]    paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;
  int            fail_count;
  int            pending;
  int            quiet_cycles;
  logic          idle_en;
  logic          hold_req;

  first_order_ambisonic_panner_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  first_order_ambisonic_panner_core_chk u_chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .pending(pending)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[first_order_ambisonic_panner_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver pacing, with one long hold-off on request
  initial begin
    bit held;
    held = 1'b0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (200) @(posedge clk);
        m_tready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // offer one item and wait for its transfer
  task automatic push(logic [1:0] kind, logic [215:0] d);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= d;
    forever begin
      @(negedge clk);
      if (s_tready) break;
    end
    @(posedge clk);
  endtask

  // stop offering and wait until every result has come
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    drain();
    repeat (SETTLE) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [215:0] dir_data(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    return {120'(0), z, y, x} | ({$urandom, $urandom, $urandom, $urandom} << 96);
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($signed($urandom) >>> $urandom_range(4, 31));
      2: return 32'd0;
      3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return 32'($signed($urandom) >>> 12);
    endcase
  endfunction

  function automatic logic [23:0] rand_smp();
    case ($urandom_range(0, 5))
      0: return 24'h800000;
      1: return 24'h7fffff;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [215:0] rand_body();
    return {rand_smp(), rand_smp(), rand_smp(), rand_smp(), rand_smp(),
            $urandom, $urandom, $urandom};
  endfunction

  task automatic rand_item();
    int r;
    logic [215:0] d;
    r = $urandom_range(0, 99);
    d = rand_body();
    if (r < 7) begin
      d[95:0] = {rand_pos(), rand_pos(), rand_pos()};
      push(fap_pkg::REQ_DIR, d);
    end else if (r < 75) begin
      push(fap_pkg::REQ_POINT, d);
    end else if (r < 96) begin
      push(fap_pkg::REQ_DIFF, d);
    end else begin
      push(REQ_UNUSED, d);
    end
  endtask

  initial begin
    logic [12:0] lens[8];
    lens = '{13'd1, 13'd2, 13'd7, 13'd64, 13'd300, 13'd4096, 13'd0, 13'd8191};
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = fap_pkg::REQ_POINT;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_en = 1'b1;
    hold_req = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, starting under reset settings
    push(fap_pkg::REQ_POINT, {96'd0, 24'h7fffff, 96'd0});
    push(fap_pkg::REQ_DIR, dir_data(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    repeat (3) push(fap_pkg::REQ_POINT, {96'd0, 24'h800000, 96'd0});
    push(fap_pkg::REQ_DIFF, {24'h800000, 24'h7fffff, 24'h800000, 24'h7fffff, 120'd0});
    push(REQ_UNUSED, {216{1'b1}});
    push(fap_pkg::REQ_DIR, dir_data(32'd0, 32'd0, 32'd0));
    repeat (2) push(fap_pkg::REQ_POINT, {96'd0, 24'h7fffff, 96'd0});
    reg_write(fap_pkg::REG_CHUNK, 32'd1);
    reg_write(fap_pkg::REG_SN3D, 32'd1);
    reg_write(fap_pkg::REG_ACN, 32'd0);
    reg_write(REG_UNUSED, 32'hffff_ffff);
    push(fap_pkg::REQ_DIFF, {24'h7fffff, 24'h800000, 24'h7fffff, 24'h7fffff, 120'd0});
    push(fap_pkg::REQ_DIFF, {24'h800000, 24'h000001, 24'hffffff, 24'h800000, 120'd0});
    push(fap_pkg::REQ_DIR, dir_data(32'h0000_0001, 32'hffff_ffff, 32'h0000_0000));
    push(fap_pkg::REQ_POINT, {96'd0, 24'h7fffff, 96'd0});
    push(fap_pkg::REQ_POINT, {96'd0, 24'h800000, 96'd0});
    push(fap_pkg::REQ_DIR, dir_data(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    push(fap_pkg::REQ_POINT, {96'd0, 24'h800000, 96'd0});
    reg_write(fap_pkg::REG_CHUNK, 32'd8191);
    push(fap_pkg::REQ_DIR, dir_data(32'h0001_0000, 32'h0000_0000, 32'h0000_0000));
    repeat (3) push(fap_pkg::REQ_POINT, {96'd0, 24'h400000, 96'd0});
    reg_write(fap_pkg::REG_CHUNK, 32'd4097);
    push(fap_pkg::REQ_DIR, dir_data(32'h0000_0000, 32'h0003_0000, 32'hfffc_0000));
    push(fap_pkg::REQ_POINT, {96'd0, 24'h7fffff, 96'd0});

    // random phases over several settings
    for (int ph = 0; ph < 8; ph++) begin
      reg_write(fap_pkg::REG_SN3D, $urandom_range(0, 1));
      reg_write(fap_pkg::REG_ACN, $urandom_range(0, 1));
      reg_write(fap_pkg::REG_CHUNK, 32'(lens[ph]));
      if (ph == 7) idle_en = 1'b0;
      for (int i = 0; i < 200; i++) begin
        if (ph == 2 && i == 50) hold_req <= 1'b1;
        if (ph == 3 && i == 100) drain();
        rand_item();
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("[first_order_ambisonic_panner_core] OK");
    end else begin
      $display("[first_order_ambisonic_panner_core] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
